>>> design/usrs_pkg.sv
// Shared types, constants and codes for the user segment register setup block.
package usrs_pkg;

    localparam int NUM_SEGMENTS   = 8;
    localparam int SEGMENT_CLICKS = 128;
    localparam int SEG_IDX_W      = 3;
    localparam int CLICK_SHIFT    = 7;

    // Access field codes of a page descriptor, bits 3:0.
    localparam logic [3:0] ACC_RO    = 4'h2;
    localparam logic [3:0] ACC_RW    = 4'h6;
    localparam logic [3:0] ACC_WRITE = 4'h4;
    localparam logic [3:0] ACC_ED    = 4'h8;

    // Configuration register indexes.
    localparam logic CFG_USER_AREA  = 1'b0;
    localparam logic CFG_MAX_MEMORY = 1'b1;

    localparam logic [7:0]  USER_AREA_RESET  = 8'd16;
    localparam logic [13:0] MAX_MEMORY_RESET = 14'd2048;

    typedef struct packed {
        logic [11:0] text_clicks;
        logic [11:0] data_clicks;
        logic [11:0] stack_clicks;
        logic [15:0] proc_base;
        logic        has_text;
        logic [15:0] text_core_base;
    } t_item;

    typedef struct packed {
        logic [2:0]  segment_index;
        logic [15:0] page_address;
        logic [15:0] page_descriptor;
        logic        failed;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  user_area_clicks;
        logic [13:0] max_memory_clicks;
    } t_cfg;

    // Per-item layout summary, worked out when the item is taken in.
    typedef struct packed {
        logic        fail;
        logic [3:0]  text_end;
        logic [3:0]  data_end;
        logic [3:0]  stack_pages;
        logic [15:0] stack_top;
    } t_layout;

endpackage

>>> design/usrs_cfg_regs.sv
// Configuration registers: user area size and memory limit.
module usrs_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [13:0]         i_cfg_data,
    output usrs_pkg::t_cfg      o_cfg
);

    usrs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.user_area_clicks  <= usrs_pkg::USER_AREA_RESET;
            r_cfg.max_memory_clicks <= usrs_pkg::MAX_MEMORY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                usrs_pkg::CFG_USER_AREA:  r_cfg.user_area_clicks  <= i_cfg_data[7:0];
                usrs_pkg::CFG_MAX_MEMORY: r_cfg.max_memory_clicks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/usrs_page_calc.sv
// Address and descriptor of one page register pair for a held item.
module usrs_page_calc (
    input  usrs_pkg::t_item     i_item,
    input  usrs_pkg::t_layout   i_layout,
    input  logic [7:0]          i_user_area,
    input  logic [2:0]          i_idx,
    output logic [15:0]         o_address,
    output logic [15:0]         o_descriptor
);

    logic        is_text;
    logic        is_data;
    logic        is_stack;
    logic [2:0]  data_j;
    logic [2:0]  stack_j;
    logic [3:0]  stack_j1;
    logic [6:0]  len;
    logic [3:0]  acc;
    logic [15:0] virt;
    logic [15:0] base;

    assign is_text  = {1'b0, i_idx} < i_layout.text_end;
    assign is_data  = {1'b0, i_idx} < i_layout.data_end;
    assign is_stack = ({1'b0, i_idx} + i_layout.stack_pages) >= 4'd8;
    assign data_j   = i_idx - i_layout.text_end[2:0];
    assign stack_j  = ~i_idx;
    assign stack_j1 = {1'b0, stack_j} + 4'd1;

    always_comb begin
        len  = 7'd0;
        acc  = 4'h0;
        virt = 16'd0;
        if (is_stack) begin
            // Stack fills downward from the top page; a partial page is expand-down.
            acc  = usrs_pkg::ACC_RW;
            virt = i_layout.stack_top - {5'd0, stack_j1, 7'd0};
            if ({2'b0, stack_j} < i_item.stack_clicks[11:7]) begin
                len = 7'd127;
            end else begin
                len = 7'd0 - i_item.stack_clicks[6:0];
                acc = usrs_pkg::ACC_RW | usrs_pkg::ACC_ED;
            end
        end else if (is_text) begin
            acc  = usrs_pkg::ACC_RO;
            virt = {6'd0, i_idx, 7'd0};
            if ({2'b0, i_idx} < i_item.text_clicks[11:7]) begin
                len = 7'd127;
            end else begin
                len = i_item.text_clicks[6:0] - 7'd1;
            end
        end else if (is_data) begin
            acc  = usrs_pkg::ACC_RW;
            virt = {8'd0, i_user_area} + {6'd0, data_j, 7'd0};
            if ({2'b0, data_j} < i_item.data_clicks[11:7]) begin
                len = 7'd127;
            end else begin
                len = i_item.data_clicks[6:0] - 7'd1;
            end
        end
    end

    // Pages without write access, unused ones included, go to the text base when there is one, else to base zero.
    always_comb begin
        if ((acc & usrs_pkg::ACC_WRITE) != 4'h0) begin
            base = i_item.proc_base;
        end else if (i_item.has_text) begin
            base = i_item.text_core_base;
        end else begin
            base = 16'd0;
        end
    end

    assign o_address    = virt + base;
    assign o_descriptor = {1'b0, len, 4'h0, acc};

endmodule

>>> design/user_segment_register_setup.sv
// Top level of the user segment register setup block.
//
// A request carries text, data and stack sizes in clicks plus the process
// base and an optional shared text base. It is taken on a clock edge where
// start is high and busy is low. The block then produces eight page register
// items, indexes 0 to 7 in order, one per clock. Each result item stands on
// o_result for exactly one cycle, marked by o_strobe; the receiver cannot
// hold it off. When the layout needs more than eight pages or exceeds the
// memory limit, a single item with failed and last set is produced instead.
// The item is registered at the accepting edge and the result register
// loads at the next one. A request occupies the shared page calculator
// while its results are computed; busy drops in the cycle the last page
// (or the error item) is computed, so requests follow each other without
// a gap. The configuration port writes the user area size (index 0) and
// the memory limit (index 1). The user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the sequencer and the strobe and restores the
// configuration defaults of 16 and 2048 clicks.
module user_segment_register_setup (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  usrs_pkg::t_item     i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [13:0]         i_cfg_data,
    output logic                o_strobe,
    output usrs_pkg::t_result   o_result
);

    usrs_pkg::t_cfg      cfg;
    usrs_pkg::t_layout   n_layout;
    usrs_pkg::t_layout   r_layout;
    usrs_pkg::t_item     r_item;
    usrs_pkg::t_result   r_result;
    usrs_pkg::t_result   n_result;
    logic                r_active;
    logic                r_strobe;
    logic [2:0]          r_idx;
    logic                finishing;
    logic                accept;
    logic [15:0]         page_address;
    logic [15:0]         page_descriptor;
    logic [5:0]          text_pages;
    logic [5:0]          data_pages;
    logic [5:0]          stack_pages;
    logic [7:0]          page_sum;
    logic [13:0]         click_sum;

    usrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Page counts round each segment up to whole 128-click pages.
    assign text_pages  = {1'b0, i_item.text_clicks[11:7]}  + {5'd0, |i_item.text_clicks[6:0]};
    assign data_pages  = {1'b0, i_item.data_clicks[11:7]}  + {5'd0, |i_item.data_clicks[6:0]};
    assign stack_pages = {1'b0, i_item.stack_clicks[11:7]} + {5'd0, |i_item.stack_clicks[6:0]};
    assign page_sum    = {2'd0, text_pages} + {2'd0, data_pages} + {2'd0, stack_pages};
    assign click_sum   = {2'd0, i_item.text_clicks} + {2'd0, i_item.data_clicks}
                       + {2'd0, i_item.stack_clicks};

    // When the layout fits, every page count is at most eight, so four bits
    // carry the region boundaries exactly.
    always_comb begin
        n_layout.fail        = (page_sum > 8'd8) || (click_sum > cfg.max_memory_clicks);
        n_layout.text_end    = text_pages[3:0];
        n_layout.data_end    = text_pages[3:0] + data_pages[3:0];
        n_layout.stack_pages = stack_pages[3:0];
        n_layout.stack_top   = {8'd0, cfg.user_area_clicks} + {4'd0, i_item.data_clicks}
                             + {4'd0, i_item.stack_clicks};
    end

    assign finishing = r_active && (r_layout.fail || (r_idx == 3'd7));
    assign busy      = r_active && !finishing;
    assign accept    = start && !busy;

    usrs_page_calc u_page (
        .i_item       (r_item),
        .i_layout     (r_layout),
        .i_user_area  (cfg.user_area_clicks),
        .i_idx        (r_idx),
        .o_address    (page_address),
        .o_descriptor (page_descriptor)
    );

    always_comb begin
        if (r_layout.fail) begin
            n_result.segment_index   = 3'd0;
            n_result.page_address    = 16'd0;
            n_result.page_descriptor = 16'd0;
            n_result.failed          = 1'b1;
            n_result.last            = 1'b1;
        end else begin
            n_result.segment_index   = r_idx;
            n_result.page_address    = page_address;
            n_result.page_descriptor = page_descriptor;
            n_result.failed          = 1'b0;
            n_result.last            = (r_idx == 3'd7);
        end
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= 3'd0;
        end else begin
            r_strobe <= r_active;
            if (accept) begin
                r_active <= 1'b1;
                r_idx    <= 3'd0;
            end else begin
                if (finishing) begin
                    r_active <= 1'b0;
                end
                if (r_active) begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_item;
            r_layout <= n_layout;
        end
        if (r_active) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_active && (r_idx == 3'd0)))
        else $error("accepted item did not start at page zero");

    a_strobe_from_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_active))
        else $error("result strobe without an item in progress");

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.failed) |-> o_result.last)
        else $error("error result not marked last");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !finishing) |=> (r_active && (r_idx == $past(r_idx) + 3'd1)))
        else $error("page index skipped or stalled");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the user segment register setup block.
`timescale 1ns / 100ps

module testbench;
    import usrs_pkg::*;

    // The watchdog limit is far above the slowest correct run: 236 requests,
    // each with its pages and an idle gap, plus the drains and register
    // writes between phases.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Cycles allowed after the last expected page before the block counts as
    // idle. The first page leaves through the item and result registers after
    // acceptance, so this is plenty.
    localparam int unsigned IDLE_SLACK = 6;

    // Keeps its own copy of the two configuration registers, works out the eight
    // page register pairs (or the single error item) for every accepted
    // request, and checks the pages that come out of the block in order.
    class segment_map_board;
        logic [7:0]  user_area  = USER_AREA_RESET;
        logic [13:0] max_memory = MAX_MEMORY_RESET;
        t_result     pending_pages[$];
        int unsigned page_errors = 0;

        function void set_limits(logic [7:0] ua, logic [13:0] mm);
            user_area  = ua;
            max_memory = mm;
        endfunction

        static function int unsigned pages_for(int unsigned clicks);
            return (clicks + SEGMENT_CLICKS - 1) / SEGMENT_CLICKS;
        endfunction

        // Descriptor: length field in bits 14:8, access code in bits 3:0.
        static function logic [15:0] desc_of(logic [6:0] len_field, logic [3:0] acc);
            return {1'b0, len_field, 4'b0000, acc};
        endfunction

        function void note_request(t_item it);
            int unsigned tc, dc, sc, k, top, i;
            logic [15:0] a, base;
            logic [15:0] vaddr [NUM_SEGMENTS];
            logic [15:0] desc  [NUM_SEGMENTS];
            t_result     r;
            tc = it.text_clicks;
            dc = it.data_clicks;
            sc = it.stack_clicks;
            if (pages_for(tc) + pages_for(dc) + pages_for(sc) > NUM_SEGMENTS ||
                tc + dc + sc > max_memory) begin
                r = '0;
                r.failed = 1'b1;
                r.last   = 1'b1;
                pending_pages.push_back(r);
                return;
            end
            for (i = 0; i < NUM_SEGMENTS; i++) begin
                vaddr[i] = '0;
                desc[i]  = '0;
            end
            // Text pages, read-only, from virtual click 0 upward.
            k = 0;
            a = '0;
            while (tc >= SEGMENT_CLICKS && k < NUM_SEGMENTS) begin
                desc[k]  = desc_of(7'(SEGMENT_CLICKS - 1), ACC_RO);
                vaddr[k] = a;
                k++;
                a  = a + 16'(SEGMENT_CLICKS);
                tc = tc - SEGMENT_CLICKS;
            end
            if (tc != 0 && k < NUM_SEGMENTS) begin
                desc[k]  = desc_of(7'(tc - 1), ACC_RO);
                vaddr[k] = a;
                k++;
            end
            // Data pages, read-write, after the user area.
            a = 16'(user_area);
            while (dc >= SEGMENT_CLICKS && k < NUM_SEGMENTS) begin
                desc[k]  = desc_of(7'(SEGMENT_CLICKS - 1), ACC_RW);
                vaddr[k] = a;
                k++;
                a  = a + 16'(SEGMENT_CLICKS);
                dc = dc - SEGMENT_CLICKS;
            end
            if (dc != 0 && k < NUM_SEGMENTS) begin
                desc[k]  = desc_of(7'(dc - 1), ACC_RW);
                vaddr[k] = a;
                k++;
                a = a + 16'(dc);
            end
            // Stack pages fill from the top register downward; a partial page
            // is expand-down and its address may wrap below zero.
            top = NUM_SEGMENTS;
            a = a + 16'(sc);
            while (sc >= SEGMENT_CLICKS && top > 0) begin
                a  = a - 16'(SEGMENT_CLICKS);
                sc = sc - SEGMENT_CLICKS;
                top--;
                desc[top]  = desc_of(7'(SEGMENT_CLICKS - 1), ACC_RW);
                vaddr[top] = a;
            end
            if (sc != 0 && top > 0) begin
                top--;
                desc[top]  = desc_of(7'(SEGMENT_CLICKS - sc), ACC_RW | ACC_ED);
                vaddr[top] = a - 16'(SEGMENT_CLICKS);
            end
            // Pages without write access (read-only and unused) go to the
            // shared text base when there is one, everything else to the
            // process base.
            for (i = 0; i < NUM_SEGMENTS; i++) begin
                if ((desc[i][3:0] & ACC_WRITE) == 4'h0) begin
                    base = it.has_text ? it.text_core_base : 16'h0000;
                end else begin
                    base = it.proc_base;
                end
                r.segment_index   = 3'(i);
                r.page_address    = vaddr[i] + base;
                r.page_descriptor = desc[i];
                r.failed          = 1'b0;
                r.last            = (i == NUM_SEGMENTS - 1);
                pending_pages.push_back(r);
            end
        endfunction

        function void check_page(t_result got);
            t_result want;
            if (pending_pages.size() == 0) begin
                $error("unexpected page item: index %0d address %h descriptor %h",
                       got.segment_index, got.page_address, got.page_descriptor);
                page_errors++;
                return;
            end
            want = pending_pages.pop_front();
            if (got.segment_index !== want.segment_index) begin
                $error("segment_index: expected %0d, actual %0d",
                       want.segment_index, got.segment_index);
                page_errors++;
            end
            if (got.page_address !== want.page_address) begin
                $error("page_address: expected %h, actual %h",
                       want.page_address, got.page_address);
                page_errors++;
            end
            if (got.page_descriptor !== want.page_descriptor) begin
                $error("page_descriptor: expected %h, actual %h",
                       want.page_descriptor, got.page_descriptor);
                page_errors++;
            end
            if (got.failed !== want.failed) begin
                $error("failed: expected %0b, actual %0b", want.failed, got.failed);
                page_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                page_errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [13:0] i_cfg_data;
    logic        o_strobe;
    t_result     o_result;

    segment_map_board board = new;
    int unsigned      cycle_count = 0;
    // When set, requests follow each other with no idle cycles at all.
    bit               no_idle = 1'b0;

    user_segment_register_setup u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost page ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result monitor. Each page item is on the outputs for exactly one cycle
    // and is taken at the edge that ends it; sampling at the edge reads the
    // values from before the block's own updates at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_page(o_result);
        end
    end

    function automatic t_item mk_request(int unsigned t, int unsigned d, int unsigned s,
                                         logic [15:0] pb, logic ht, logic [15:0] tb);
        t_item it;
        it.text_clicks    = 12'(t);
        it.data_clicks    = 12'(d);
        it.stack_clicks   = 12'(s);
        it.proc_base      = pb;
        it.has_text       = ht;
        it.text_core_base = tb;
        return it;
    endfunction

    // Size in clicks that needs exactly the given number of pages; a quarter
    // of the time the last page is completely full.
    function automatic int unsigned clicks_for(int unsigned pages);
        if (pages == 0) begin
            return 0;
        end
        return (pages - 1) * SEGMENT_CLICKS +
               (($urandom_range(0, 3) == 0) ? SEGMENT_CLICKS : $urandom_range(1, 127));
    endfunction

    // Most requests are well-formed layouts of up to eight pages with random
    // sizes and bases. Some need exactly nine pages, and a few are plain
    // noise over the full field ranges, which nearly always fail.
    function automatic t_item random_request();
        int unsigned roll, tp, dp, sp;
        t_item       it;
        roll = $urandom_range(0, 99);
        tp = $urandom_range(0, NUM_SEGMENTS);
        dp = $urandom_range(0, NUM_SEGMENTS - tp);
        if (roll < 40) begin
            sp = NUM_SEGMENTS - tp - dp;
        end else if (roll < 90) begin
            sp = $urandom_range(0, NUM_SEGMENTS - tp - dp);
        end else begin
            sp = NUM_SEGMENTS + 1 - tp - dp;
        end
        it = mk_request(clicks_for(tp), clicks_for(dp), clicks_for(sp),
                        16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                        16'($urandom_range(0, 16'hFFFF)));
        if (roll < 8) begin
            it.text_clicks  = 12'($urandom_range(0, 12'hFFF));
            it.data_clicks  = 12'($urandom_range(0, 12'hFFF));
            it.stack_clicks = 12'($urandom_range(0, 12'hFFF));
        end
        return it;
    endfunction

    // Idle gap after a request: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 80) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until an edge sees start high with
    // busy low. With no gap, start simply stays high for the next item, so
    // it is never lowered and raised in the same time step.
    task automatic send_request(input t_item it);
        int unsigned gap;
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (busy);
        board.note_request(it);
        gap = pick_gap();
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= t_item'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++) begin
            // Every dozen requests decide afresh whether to run back to back.
            if (n % 12 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request());
        end
    endtask

    // Stop requesting, wait for every expected page, then wait out the idle
    // slack so that nothing is in flight.
    task automatic settle();
        start <= 1'b0;
        while (board.pending_pages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_SLACK) @(posedge i_clk);
    endtask

    // Writes the user area register, then the memory limit register; only called while
    // the block is idle.
    task automatic write_limits(input logic [7:0] ua, input logic [13:0] mm);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_USER_AREA;
        i_cfg_data  <= 14'(ua);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_MEMORY;
        i_cfg_data  <= mm;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_limits(ua, mm);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_USER_AREA;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset defaults (user area 16, limit
        // 2048). An empty layout leaves all eight pages unused, and unused
        // pages land on the shared text base when there is one.
        send_request(mk_request(0, 0, 0, 16'h0000, 1'b0, 16'h0000));
        send_request(mk_request(0, 0, 0, 16'hFFFF, 1'b1, 16'hFFFF));
        send_request(mk_request(1, 1, 1, 16'h1234, 1'b1, 16'h0800));
        // Without shared text, text pages keep their virtual address.
        send_request(mk_request(1, 1, 1, 16'h4321, 1'b0, 16'hABCD));
        // Sizes on exact page boundaries, and a layout using all eight pages.
        send_request(mk_request(128, 128, 128, 16'h0100, 1'b1, 16'h0200));
        send_request(mk_request(384, 384, 256, 16'h2000, 1'b1, 16'h3000));
        // Stack only, eight full pages; then a lone partial stack page.
        send_request(mk_request(0, 0, 1024, 16'h0040, 1'b0, 16'h0000));
        send_request(mk_request(0, 0, 127, 16'h0000, 1'b0, 16'h0000));
        // Address wrap past the top of the 16-bit space, text and data side.
        send_request(mk_request(1024, 0, 0, 16'h0000, 1'b1, 16'hFF80));
        send_request(mk_request(0, 1024, 0, 16'hFFFF, 1'b0, 16'h0000));
        // Nine pages needed, and every size field at its maximum.
        send_request(mk_request(300, 300, 300, 16'h1111, 1'b1, 16'h2222));
        send_request(mk_request(4095, 4095, 4095, 16'hFFFF, 1'b1, 16'hFFFF));
        settle();

        // Tight memory limit with the largest user area: a layout exactly at
        // the limit fits, one click more fails on memory alone.
        write_limits(8'd255, 14'd600);
        send_request(mk_request(200, 200, 200, 16'hF000, 1'b1, 16'h0F00));
        send_request(mk_request(200, 200, 201, 16'hF000, 1'b1, 16'h0F00));
        settle();

        // No user area and a limit above any layout's size. A small stack with nothing
        // below it makes its expand-down page address wrap below zero.
        write_limits(8'd0, 14'd12288);
        send_request(mk_request(0, 0, 1, 16'h0000, 1'b0, 16'h0000));
        send_request(mk_request(0, 127, 129, 16'h8000, 1'b1, 16'h7FFF));
        send_request(mk_request(129, 0, 0, 16'h5555, 1'b1, 16'hAAAA));
        run_random(52);
        settle();

        write_limits(8'd255, 14'd600);
        run_random(52);
        settle();

        write_limits(8'($urandom_range(0, 255)), 14'($urandom_range(0, 12288)));
        run_random(52);
        settle();

        // A zero limit rejects every request except an empty one.
        write_limits(8'($urandom_range(0, 255)), 14'd0);
        send_request(mk_request(0, 0, 0, 16'h0F0F, 1'b1, 16'hF0F0));
        run_random(10);
        settle();

        write_limits(USER_AREA_RESET, MAX_MEMORY_RESET);
        run_random(52);
        settle();

        if (board.page_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
